// ===== rtl/core/fbc_pkg.sv =====
// Package with the constants, item types and control structs of the block cache.
`default_nettype none
package fbc_pkg;

    localparam int ENTRIES     = 16;
    localparam int BLOCK_WORDS = 64;
    localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int MEM_DEPTH   = ENTRIES * BLOCK_WORDS;
    localparam int ADDR_W      = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_ADD    = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [31:0] block_number;
        logic [5:0]  word_index;
        logic [63:0] data_word;
    } in_item_t;

    typedef struct packed {
        logic        hit;
        logic [63:0] read_word;
    } out_item_t;

    typedef struct packed {
        logic capture;
        logic access;
        logic load_out;
    } fbc_cmd_t;

    typedef struct packed {
        logic out_busy;
    } fbc_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/fbc_datapath.sv =====
// Datapath of the block cache: tag registers, replace pointer, data memory and output register.
`default_nettype none
module fbc_datapath (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire fbc_pkg::in_item_t    s_item,
    input  wire fbc_pkg::fbc_cmd_t    cmd,
    output fbc_pkg::fbc_status_t      status,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output fbc_pkg::out_item_t        m_item
);
    import fbc_pkg::*;

    logic [ENTRIES-1:0] valid_reg;
    logic [31:0]        tag_reg [ENTRIES];
    logic [IDX_W-1:0]   ptr_reg;
    logic [63:0]        mem [MEM_DEPTH];

    in_item_t           item_reg;
    logic               hit_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               hit_next;
    logic [IDX_W-1:0]   idx_next;

    logic [63:0]        rdata_reg;
    logic               rd_en_reg;
    logic               res_hit_reg;
    out_item_t          out_reg;
    logic               out_valid_reg;

    logic [IDX_W-1:0]   slot;
    logic               word_ok;
    logic [ADDR_W-1:0]  addr;

    // Parallel tag compare; the lowest matching entry wins.
    always_comb begin
        hit_next = 1'b0;
        idx_next = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (valid_reg[i] && (tag_reg[i] == s_item.block_number)) begin
                hit_next = 1'b1;
                idx_next = IDX_W'(i);
            end
        end
    end

    assign slot    = hit_reg ? idx_reg : ptr_reg;
    assign word_ok = (32'(item_reg.word_index) < 32'(BLOCK_WORDS));
    assign addr    = ADDR_W'(32'(slot) * BLOCK_WORDS + 32'(item_reg.word_index));

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg <= s_item;
            hit_reg  <= hit_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            ptr_reg   <= '0;
        end else if (cmd.access && (item_reg.kind == KIND_ADD) && !hit_reg) begin
            valid_reg[ptr_reg] <= 1'b1;
            if (ptr_reg == IDX_W'(ENTRIES - 1)) begin
                ptr_reg <= '0;
            end else begin
                ptr_reg <= ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.access && (item_reg.kind == KIND_ADD) && !hit_reg) begin
            tag_reg[ptr_reg] <= item_reg.block_number;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.access) begin
            if ((item_reg.kind == KIND_ADD) && word_ok) begin
                mem[addr] <= item_reg.data_word;
            end
            rdata_reg <= mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.access) begin
            rd_en_reg   <= (item_reg.kind == KIND_LOOKUP) && hit_reg && word_ok;
            res_hit_reg <= hit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_reg.hit       <= res_hit_reg;
            out_reg.read_word <= rd_en_reg ? rdata_reg : 64'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.out_busy = out_valid_reg;
    assign m_valid         = out_valid_reg;
    assign m_item          = out_reg;

endmodule
`default_nettype wire

// ===== rtl/core/fbc_ctrl.sv =====
// Controller state machine of the block cache.
`default_nettype none
module fbc_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 m_ready,
    input  wire fbc_pkg::fbc_status_t status,
    output fbc_pkg::fbc_cmd_t         cmd
);
    import fbc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MEM  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_free;

    assign out_free     = !status.out_busy || m_ready;
    assign s_ready      = (state_reg == ST_IDLE);
    assign cmd.capture  = s_valid && s_ready;
    assign cmd.access   = (state_reg == ST_MEM);
    assign cmd.load_out = (state_reg == ST_DONE) && out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_MEM;
                end
            end
            ST_MEM: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/fifo_block_cache.sv =====
// Top level of the fully associative block cache with FIFO replacement.
// Each item passes through these steps: the cycle of acceptance, in which the block number is
// compared against all tag registers at once, the data memory port access (read or write), and
// the output register load, which waits while an earlier result there is not yet taken. The next
// item is taken once its predecessor is in the output register, even while that result waits for
// m_ready. No clearing pass is needed after reset: valid bits in flip-flops clear at once.
`default_nettype none
module fifo_block_cache (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire fbc_pkg::in_item_t  s_item,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output fbc_pkg::out_item_t      m_item
);
    import fbc_pkg::*;

    fbc_cmd_t    cmd;
    fbc_status_t status;

    fbc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    fbc_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule
`default_nettype wire

// ===== sim/fifo_block_cache_tb.sv =====
// Self-checking testbench for the FIFO-replacement block cache: directed and random items.
`timescale 1ns / 100ps
`default_nettype none
module fifo_block_cache_tb;
    import fbc_pkg::*;

    localparam int TOTAL_ITEMS = 875;
    localparam int POOL_SIZE   = 24;

    class cache_scoreboard;
        bit            entry_used[ENTRIES];
        bit [31:0]     entry_tag[ENTRIES];
        bit [63:0]     block_store[MEM_DEPTH];
        bit            word_written[MEM_DEPTH];
        int            fill_ptr;
        out_item_t     awaited_results[$];
        int            errors;
        int            n_lookup;
        int            n_lookup_hit;
        int            n_add;
        int            n_evict;
        int            n_checked;

        function int find_entry(bit [31:0] tag);
            for (int i = 0; i < ENTRIES; i++) begin
                if (entry_used[i] && entry_tag[i] == tag) begin
                    return i;
                end
            end
            return -1;
        endfunction

        // Steers a lookup that hits away from words never written since reset.
        function in_item_t safe_lookup(in_item_t it);
            int e;
            int w;
            if (it.kind != KIND_LOOKUP) begin
                return it;
            end
            e = find_entry(it.block_number);
            if (e < 0 || it.word_index >= BLOCK_WORDS) begin
                return it;
            end
            for (int k = 0; k < BLOCK_WORDS; k++) begin
                w = (int'(it.word_index) + k) % BLOCK_WORDS;
                if (word_written[e * BLOCK_WORDS + w]) begin
                    it.word_index = 6'(w);
                    return it;
                end
            end
            return it;
        endfunction

        function void predict_access(in_item_t it);
            int        e;
            int        a;
            out_item_t exp_item;
            e = find_entry(it.block_number);
            exp_item.hit = (e >= 0);
            exp_item.read_word = '0;
            if (it.kind == KIND_LOOKUP) begin
                n_lookup++;
                if (e >= 0) begin
                    n_lookup_hit++;
                    if (it.word_index < BLOCK_WORDS) begin
                        exp_item.read_word = block_store[e * BLOCK_WORDS + it.word_index];
                    end
                end
            end else begin
                n_add++;
                if (e < 0) begin
                    e = fill_ptr;
                    if (entry_used[e]) begin
                        n_evict++;
                    end
                    fill_ptr = (fill_ptr + 1) % ENTRIES;
                    entry_used[e] = 1'b1;
                    entry_tag[e] = it.block_number;
                end
                if (it.word_index < BLOCK_WORDS) begin
                    a = e * BLOCK_WORDS + it.word_index;
                    block_store[a] = it.data_word;
                    word_written[a] = 1'b1;
                end
            end
            awaited_results.push_back(exp_item);
        endfunction

        task report(string msg);
            $display("[%0t] ERROR: %s", $time, msg);
            errors++;
        endtask

        task check_result(out_item_t got);
            out_item_t exp_item;
            if (awaited_results.size() == 0) begin
                report($sformatf("unexpected result hit=%0b word=%h", got.hit, got.read_word));
                return;
            end
            exp_item = awaited_results.pop_front();
            n_checked++;
            if (got.hit !== exp_item.hit) begin
                report($sformatf("result %0d: hit got %0b, expected %0b",
                                 n_checked, got.hit, exp_item.hit));
            end
            if (got.read_word !== exp_item.read_word) begin
                report($sformatf("result %0d: read_word got %h, expected %h",
                                 n_checked, got.read_word, exp_item.read_word));
            end
        endtask

        function int pending();
            return awaited_results.size();
        endfunction
    endclass

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;

    cache_scoreboard sb;
    int              sent;
    int              burst_left;
    bit [31:0]       tag_pool[POOL_SIZE];

    fifo_block_cache dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_item (s_item),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_item (m_item)
    );

    always #1 aclk = ~aclk;

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic in_item_t make_item(logic kind, logic [31:0] tag, logic [5:0] word,
                                           logic [63:0] data);
        in_item_t it;
        it.kind = kind;
        it.block_number = tag;
        it.word_index = word;
        it.data_word = data;
        return it;
    endfunction

    function automatic logic [31:0] pick_tag();
        return tag_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    // Sends one item and, at the end of a burst, leaves a random gap.
    task automatic push_item(in_item_t raw);
        in_item_t it;
        int       gap;
        it = sb.safe_lookup(raw);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_item <= it;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        sb.predict_access(it);
        sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 6);
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(0, 10);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_item);
        end
    end

    initial begin
        int unsigned cyc;
        int          stall_left;
        logic        r;
        cyc = 0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            cyc++;
            case ((cyc / 64) % 4)
                0: begin
                    r = 1'b1;
                end
                1: begin
                    r = ($urandom_range(0, 9) < 7);
                end
                2: begin
                    if (stall_left > 0) begin
                        stall_left--;
                        r = 1'b0;
                    end else begin
                        r = 1'b1;
                        if ($urandom_range(0, 3) == 0) begin
                            stall_left = $urandom_range(1, 12);
                        end
                    end
                end
                default: begin
                    r = ($urandom_range(0, 9) < 3);
                end
            endcase
            m_ready <= r;
        end
    end

    initial begin
        #500000;
        $display("Timeout with %0d results outstanding", sb.pending());
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int        r;
        int        n;
        logic [31:0] tag;
        aclk = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item = '0;
        m_ready = 1'b0;
        sent = 0;
        burst_left = $urandom_range(0, 10);
        sb = new();
        tag_pool[0] = 32'h0000_0000;
        tag_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++) begin
            tag_pool[i] = $urandom;
        end
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Misses on the empty cache, both extreme tags and word indexes, then a full fill
        // and the first eviction, which also exposes stale data left in the reused entry.
        push_item(make_item(KIND_LOOKUP, 32'h0000_0000, 6'd0, rand_word()));
        push_item(make_item(KIND_LOOKUP, 32'hFFFF_FFFF, 6'd63, rand_word()));
        push_item(make_item(KIND_ADD, 32'h0000_0000, 6'd0, 64'hFFFF_FFFF_FFFF_FFFF));
        push_item(make_item(KIND_ADD, 32'h0000_0000, 6'd63, 64'h0));
        push_item(make_item(KIND_LOOKUP, 32'h0000_0000, 6'd0, rand_word()));
        push_item(make_item(KIND_LOOKUP, 32'h0000_0000, 6'd63, 64'hFFFF_FFFF_FFFF_FFFF));
        push_item(make_item(KIND_ADD, 32'hFFFF_FFFF, 6'd0, 64'h5555_5555_AAAA_AAAA));
        push_item(make_item(KIND_LOOKUP, 32'hFFFF_FFFF, 6'd0, 64'h0));
        for (int i = 1; i <= ENTRIES - 2; i++) begin
            push_item(make_item(KIND_ADD, i, 6'd0, rand_word()));
        end
        push_item(make_item(KIND_ADD, 32'h1234_5678, 6'd0, rand_word()));
        push_item(make_item(KIND_LOOKUP, 32'h0000_0000, 6'd0, rand_word()));
        push_item(make_item(KIND_LOOKUP, 32'h1234_5678, 6'd63, rand_word()));

        while (sent < TOTAL_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                tag = pick_tag();
                n = $urandom_range(1, 8);
                for (int k = 0; k < n; k++) begin
                    push_item(make_item(KIND_ADD, tag, (k == 0) ? 6'd0 : 6'($urandom_range(0, 63)),
                                        rand_word()));
                end
            end else if (r < 85) begin
                tag = pick_tag();
                n = $urandom_range(1, 6);
                for (int k = 0; k < n; k++) begin
                    push_item(make_item(KIND_LOOKUP, tag, 6'($urandom_range(0, 63)),
                                        rand_word()));
                end
            end else begin
                tag = ($urandom_range(0, 1) == 1) ? $urandom : pick_tag();
                push_item(make_item(($urandom_range(0, 1) == 1) ? KIND_ADD : KIND_LOOKUP, tag,
                                    6'($urandom_range(0, 63)), rand_word()));
                tag_pool[$urandom_range(2, POOL_SIZE - 1)] = $urandom;
            end
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        while (sb.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
        $display("Covered %0d lookups (%0d hits) and %0d adds with %0d evictions.",
                 sb.n_lookup, sb.n_lookup_hit, sb.n_add, sb.n_evict);
        $display("Checked %0d results, %0d mismatches.", sb.n_checked, sb.errors);
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
